[hdl/rear_lamp_blinker_controller_macros.svh]
// Assertion shorthands used by rlb_core.
`ifndef REAR_LAMP_BLINKER_CONTROLLER_MACROS_SVH
`define REAR_LAMP_BLINKER_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RLB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RLB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/rlb_pkg.sv]
`default_nettype none

package rlb_pkg;

  localparam int unsigned LampCount = 8;

  // Bit positions of the latched lamp levels.
  localparam int unsigned LAMP_DIR   = 0;
  localparam int unsigned LAMP_CIRC  = 1;
  localparam int unsigned LAMP_SIDEP = 2;
  localparam int unsigned LAMP_WHOLE = 3;
  localparam int unsigned LAMP_SSTOP = 4;
  localparam int unsigned LAMP_MSTOP = 5;
  localparam int unsigned LAMP_REV   = 6;
  localparam int unsigned LAMP_SAFE  = 7;

  localparam int unsigned CfgIndexBits = 2;
  localparam int unsigned CfgDataBits  = 16;

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_BOARD_IS_LEFT   = 2'd0,
    CFG_BLINK_PERIOD_MS = 2'd1,
    CFG_BLINK_HIGH_MS   = 2'd2,
    CFG_SAFE_HOLD_MS    = 2'd3
  } cfg_index_e;

  localparam logic [15:0] BlinkPeriodReset = 16'd1000;
  localparam logic [15:0] BlinkHighReset   = 16'd500;
  localparam logic [15:0] SafeHoldReset    = 16'd3000;

  typedef struct packed {
    logic        board_is_left;
    logic [15:0] blink_period_ms;
    logic [15:0] blink_high_ms;
    logic [15:0] safe_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic left_turn;
    logic right_turn;
    logic hazard;
    logic position_on;
    logic brake_on;
    logic reverse_on;
    logic indicator_changed;
    logic position_changed;
    logic brake_changed;
    logic reverse_changed;
    logic safe_request;
  } cmd_t;

endpackage

`default_nettype wire

[hdl/rlb_core.sv]
`default_nettype none

`include "rear_lamp_blinker_controller_macros.svh"

module rlb_core
  import rlb_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 pass_i,
  input  wire logic [TIME_BITS-1:0] now_i,
  input  wire cmd_t                 cmd_i,
  input  wire cfg_t                 cfg_i,
  output logic [LampCount-1:0]      lamps_o
);

  logic                 phase_high_q, phase_high_d;
  logic [TIME_BITS-1:0] blink_mark_q, blink_mark_d;
  logic                 pending_q, pending_d;
  logic                 safe_active_q, safe_active_d;
  logic [TIME_BITS-1:0] safe_mark_q, safe_mark_d;
  logic [LampCount-1:0] lamp_q, lamp_d;

  logic [15:0]          low_ms;
  logic                 blink_run;
  logic [TIME_BITS-1:0] blink_elapsed;
  logic [TIME_BITS-1:0] safe_elapsed;

  always_comb begin
    low_ms = (cfg_i.blink_period_ms > cfg_i.blink_high_ms) ?
             (cfg_i.blink_period_ms - cfg_i.blink_high_ms) : 16'd0;
    blink_run = (cmd_i.left_turn & cfg_i.board_is_left) | cmd_i.hazard |
                (cmd_i.right_turn & ~cfg_i.board_is_left);
    blink_elapsed = now_i - blink_mark_q;

    phase_high_d  = phase_high_q;
    blink_mark_d  = blink_mark_q;
    pending_d     = pending_q | cmd_i.indicator_changed;
    safe_active_d = safe_active_q;
    safe_mark_d   = safe_mark_q;
    lamp_d        = lamp_q;

    if (blink_run) begin
      if (phase_high_q) begin
        if (blink_elapsed >= TIME_BITS'(cfg_i.blink_high_ms)) begin
          lamp_d[LAMP_DIR] = 1'b0;
          if (cmd_i.position_on) begin
            lamp_d[LAMP_CIRC] = 1'b1;
          end
          phase_high_d = 1'b0;
          blink_mark_d = now_i;
        end
      end else begin
        if (blink_elapsed >= TIME_BITS'(low_ms)) begin
          lamp_d[LAMP_CIRC] = 1'b0;
          lamp_d[LAMP_DIR]  = 1'b1;
          phase_high_d = 1'b1;
          blink_mark_d = now_i;
        end
      end
    end else if (pending_d) begin
      // A turn or hazard change only lands once blinking has stopped.
      pending_d        = 1'b0;
      lamp_d[LAMP_DIR] = 1'b0;
      phase_high_d     = 1'b0;
      if (cmd_i.position_on) begin
        lamp_d[LAMP_CIRC] = 1'b1;
      end
    end

    if (cmd_i.position_changed) begin
      lamp_d[LAMP_SIDEP] = cmd_i.position_on;
      if (cfg_i.board_is_left) begin
        lamp_d[LAMP_WHOLE] = cmd_i.position_on;
      end
      // The circles stay dark while the turn lamp is lit.
      if (!cmd_i.position_on || !phase_high_d) begin
        lamp_d[LAMP_CIRC] = cmd_i.position_on;
      end
    end
    if (cmd_i.brake_changed) begin
      lamp_d[LAMP_SSTOP] = cmd_i.brake_on;
      if (!cfg_i.board_is_left) begin
        lamp_d[LAMP_MSTOP] = cmd_i.brake_on;
      end
    end
    if (cmd_i.reverse_changed) begin
      lamp_d[LAMP_REV] = cmd_i.reverse_on;
    end

    if (cmd_i.safe_request) begin
      safe_active_d     = 1'b1;
      safe_mark_d       = now_i;
      lamp_d[LAMP_SAFE] = 1'b1;
    end
    safe_elapsed = now_i - safe_mark_d;
    if (safe_active_d && (safe_elapsed > TIME_BITS'(cfg_i.safe_hold_ms))) begin
      lamp_d[LAMP_SAFE] = 1'b0;
      safe_active_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_high_q  <= 1'b0;
      blink_mark_q  <= '0;
      pending_q     <= 1'b0;
      safe_active_q <= 1'b0;
      safe_mark_q   <= '0;
      lamp_q        <= '0;
    end else if (pass_i) begin
      phase_high_q  <= phase_high_d;
      blink_mark_q  <= blink_mark_d;
      pending_q     <= pending_d;
      safe_active_q <= safe_active_d;
      safe_mark_q   <= safe_mark_d;
      lamp_q        <= lamp_d;
    end
  end

  assign lamps_o = lamp_q;

  `RLB_ASSERT_IMP(a_dir_tracks_phase, clk_i, rst_ni, 1'b1,
                  lamp_q[LAMP_DIR] == phase_high_q, "turn lamp out of step with phase")
  `RLB_ASSERT_IMP(a_dir_circ_excl, clk_i, rst_ni, 1'b1,
                  !(lamp_q[LAMP_DIR] && lamp_q[LAMP_CIRC]), "circles lit with turn lamp")
  `RLB_ASSERT_IMP(a_safe_lamp_active, clk_i, rst_ni, lamp_q[LAMP_SAFE],
                  safe_active_q, "safe lamp lit without active hold")
  `RLB_ASSERT_NXT(a_safe_request_lights, clk_i, rst_ni, pass_i && cmd_i.safe_request,
                  lamp_q[LAMP_SAFE] && safe_active_q, "safe request did not light lamp")
  `RLB_ASSERT_NXT(a_idle_holds, clk_i, rst_ni, !pass_i,
                  $stable(lamp_q) && $stable(blink_mark_q), "state moved without a pass")

endmodule

`default_nettype wire

[hdl/rear_lamp_blinker_controller.sv]
// An accepted word is held in the input register, then its lamp levels show from the lamp register.
// Throughput: one word per cycle with no gap; while a result waits, the input register
// takes one more word and then the input stalls until the result is taken.
// Reset: asynchronous, active low; all lamps off, blink and safe timers cleared,
// configuration back to left board, 1000 ms period, 500 ms on-time, 3000 ms hold.
`default_nettype none

module rear_lamp_blinker_controller
  import rlb_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIndexBits-1:0] cfg_index_i,
  input  wire logic [CfgDataBits-1:0]  cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [TIME_BITS-1:0]    now_ms_i,
  input  wire logic                    left_turn_i,
  input  wire logic                    right_turn_i,
  input  wire logic                    hazard_i,
  input  wire logic                    position_on_i,
  input  wire logic                    brake_on_i,
  input  wire logic                    reverse_on_i,
  input  wire logic                    indicator_changed_i,
  input  wire logic                    position_changed_i,
  input  wire logic                    brake_changed_i,
  input  wire logic                    reverse_changed_i,
  input  wire logic                    safe_request_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         direction_lamp_o,
  output logic                         circles_lamp_o,
  output logic                         side_position_lamp_o,
  output logic                         whole_position_lamp_o,
  output logic                         side_stop_lamp_o,
  output logic                         middle_stop_lamp_o,
  output logic                         reverse_lamp_o,
  output logic                         safe_lamp_o
);

  cfg_t                 cfg_q;
  logic                 in_vld_q;
  logic [TIME_BITS-1:0] now_q;
  cmd_t                 cmd_q;
  cmd_t                 cmd_in;
  logic                 out_vld_q;
  logic                 advance;
  logic                 in_take;
  logic [LampCount-1:0] lamps;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.board_is_left   <= 1'b1;
      cfg_q.blink_period_ms <= BlinkPeriodReset;
      cfg_q.blink_high_ms   <= BlinkHighReset;
      cfg_q.safe_hold_ms    <= SafeHoldReset;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_BOARD_IS_LEFT:   cfg_q.board_is_left   <= cfg_data_i[0];
        CFG_BLINK_PERIOD_MS: cfg_q.blink_period_ms <= cfg_data_i;
        CFG_BLINK_HIGH_MS:   cfg_q.blink_high_ms   <= cfg_data_i;
        CFG_SAFE_HOLD_MS:    cfg_q.safe_hold_ms    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cmd_in = '{
    left_turn:         left_turn_i,
    right_turn:        right_turn_i,
    hazard:            hazard_i,
    position_on:       position_on_i,
    brake_on:          brake_on_i,
    reverse_on:        reverse_on_i,
    indicator_changed: indicator_changed_i,
    position_changed:  position_changed_i,
    brake_changed:     brake_changed_i,
    reverse_changed:   reverse_changed_i,
    safe_request:      safe_request_i
  };

  // The held word moves into the lamp register whenever that register is free or drains.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      now_q <= now_ms_i;
      cmd_q <= cmd_in;
    end
  end

  rlb_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pass_i  (advance),
    .now_i   (now_q),
    .cmd_i   (cmd_q),
    .cfg_i   (cfg_q),
    .lamps_o (lamps)
  );

  assign out_valid_o           = out_vld_q;
  assign direction_lamp_o      = lamps[LAMP_DIR];
  assign circles_lamp_o        = lamps[LAMP_CIRC];
  assign side_position_lamp_o  = lamps[LAMP_SIDEP];
  assign whole_position_lamp_o = lamps[LAMP_WHOLE];
  assign side_stop_lamp_o      = lamps[LAMP_SSTOP];
  assign middle_stop_lamp_o    = lamps[LAMP_MSTOP];
  assign reverse_lamp_o        = lamps[LAMP_REV];
  assign safe_lamp_o           = lamps[LAMP_SAFE];

endmodule

`default_nettype wire

[verif/rear_lamp_blinker_controller_test.sv]
`timescale 1ns / 1ps

module rear_lamp_blinker_controller_test;
  import rlb_pkg::*;

  localparam int unsigned TimeBits        = 32;
  localparam int unsigned CycleLimit      = 1000000;
  localparam int unsigned ShownMismatches = 30;

  typedef logic [LampCount-1:0] lamp_vec_t;

  typedef struct packed {
    logic [TimeBits-1:0] now_ms;
    cmd_t                cmd;
  } pass_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [CfgIndexBits-1:0] cfg_index_i = '0;
  logic [CfgDataBits-1:0]  cfg_data_i  = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    out_stall_i = 1'b0;
  pass_t                   offered     = '0;
  logic                    in_stall_o;
  logic                    out_valid_o;
  logic                    direction_lamp_o;
  logic                    circles_lamp_o;
  logic                    side_position_lamp_o;
  logic                    whole_position_lamp_o;
  logic                    side_stop_lamp_o;
  logic                    middle_stop_lamp_o;
  logic                    reverse_lamp_o;
  logic                    safe_lamp_o;

  // Shadow of the block: configuration, timers and the latched lamp word.
  cfg_t                board_cfg;
  logic                phase_high;
  logic [TimeBits-1:0] blink_mark;
  logic                ind_pending;
  logic                safe_on;
  logic [TimeBits-1:0] safe_mark;
  lamp_vec_t           lamps_model;
  lamp_vec_t           lamp_words_due[$];

  // Stimulus state: held command levels and the running timestamp.
  cmd_t                held_levels = '0;
  logic [TimeBits-1:0] road_time_ms = '0;

  int unsigned passes_sent      = 0;
  int unsigned words_checked    = 0;
  int unsigned mismatch_count   = 0;
  int unsigned settings_applied = 0;
  int unsigned dir_changes      = 0;
  int unsigned safe_requests    = 0;
  int unsigned cycle_count      = 0;
  int unsigned tx_calm_items    = 0;
  logic        tx_calm          = 1'b0;
  int unsigned rx_calm_cycles   = 0;
  logic        rx_calm          = 1'b0;
  int unsigned stall_run        = 0;

  rear_lamp_blinker_controller #(
    .TIME_BITS(TimeBits)
  ) i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .now_ms_i             (offered.now_ms),
    .left_turn_i          (offered.cmd.left_turn),
    .right_turn_i         (offered.cmd.right_turn),
    .hazard_i             (offered.cmd.hazard),
    .position_on_i        (offered.cmd.position_on),
    .brake_on_i           (offered.cmd.brake_on),
    .reverse_on_i         (offered.cmd.reverse_on),
    .indicator_changed_i  (offered.cmd.indicator_changed),
    .position_changed_i   (offered.cmd.position_changed),
    .brake_changed_i      (offered.cmd.brake_changed),
    .reverse_changed_i    (offered.cmd.reverse_changed),
    .safe_request_i       (offered.cmd.safe_request),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .direction_lamp_o     (direction_lamp_o),
    .circles_lamp_o       (circles_lamp_o),
    .side_position_lamp_o (side_position_lamp_o),
    .whole_position_lamp_o(whole_position_lamp_o),
    .side_stop_lamp_o     (side_stop_lamp_o),
    .middle_stop_lamp_o   (middle_stop_lamp_o),
    .reverse_lamp_o       (reverse_lamp_o),
    .safe_lamp_o          (safe_lamp_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic cfg_t cfg_of(input logic left, input logic [15:0] period,
                                  input logic [15:0] high, input logic [15:0] hold);
    cfg_t c;
    c.board_is_left   = left;
    c.blink_period_ms = period;
    c.blink_high_ms   = high;
    c.safe_hold_ms    = hold;
    return c;
  endfunction

  // The off phase of the turn lamp never goes below zero.
  function automatic logic [15:0] low_time();
    if (board_cfg.blink_period_ms > board_cfg.blink_high_ms) begin
      return board_cfg.blink_period_ms - board_cfg.blink_high_ms;
    end
    return 16'd0;
  endfunction

  function automatic string lamp_name(input int unsigned k);
    case (k)
      LAMP_DIR:   return "direction";
      LAMP_CIRC:  return "circles";
      LAMP_SIDEP: return "side_position";
      LAMP_WHOLE: return "whole_position";
      LAMP_SSTOP: return "side_stop";
      LAMP_MSTOP: return "middle_stop";
      LAMP_REV:   return "reverse";
      default:    return "safe";
    endcase
  endfunction

  // Upper case letters are command levels, lower case letters are pulses.
  function automatic pass_t pass_of(input logic [TimeBits-1:0] now, input string flags);
    pass_t p;
    p = '0;
    p.now_ms = now;
    for (int k = 0; k < flags.len(); k++) begin
      case (flags[k])
        "L": p.cmd.left_turn = 1'b1;
        "R": p.cmd.right_turn = 1'b1;
        "H": p.cmd.hazard = 1'b1;
        "P": p.cmd.position_on = 1'b1;
        "B": p.cmd.brake_on = 1'b1;
        "V": p.cmd.reverse_on = 1'b1;
        "i": p.cmd.indicator_changed = 1'b1;
        "p": p.cmd.position_changed = 1'b1;
        "b": p.cmd.brake_changed = 1'b1;
        "v": p.cmd.reverse_changed = 1'b1;
        "s": p.cmd.safe_request = 1'b1;
        default: ;
      endcase
    end
    return p;
  endfunction

  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic reset_model();
    board_cfg   = cfg_of(1'b1, BlinkPeriodReset, BlinkHighReset, SafeHoldReset);
    phase_high  = 1'b0;
    blink_mark  = '0;
    ind_pending = 1'b0;
    safe_on     = 1'b0;
    safe_mark   = '0;
    lamps_model = '0;
  endtask

  task automatic compute_lamp_levels(input pass_t p);
    cmd_t                c;
    logic                is_left;
    logic [TimeBits-1:0] elapsed;
    logic                dir_before;
    c          = p.cmd;
    is_left    = board_cfg.board_is_left;
    dir_before = lamps_model[LAMP_DIR];
    if (c.indicator_changed) ind_pending = 1'b1;
    if ((c.left_turn && is_left) || c.hazard || (c.right_turn && !is_left)) begin
      elapsed = p.now_ms - blink_mark;
      if (phase_high) begin
        if (elapsed >= TimeBits'(board_cfg.blink_high_ms)) begin
          lamps_model[LAMP_DIR] = 1'b0;
          if (c.position_on) lamps_model[LAMP_CIRC] = 1'b1;
          phase_high = 1'b0;
          blink_mark = p.now_ms;
        end
      end else if (elapsed >= TimeBits'(low_time())) begin
        lamps_model[LAMP_CIRC] = 1'b0;
        lamps_model[LAMP_DIR]  = 1'b1;
        phase_high = 1'b1;
        blink_mark = p.now_ms;
      end
    end else if (ind_pending) begin
      ind_pending           = 1'b0;
      lamps_model[LAMP_DIR] = 1'b0;
      phase_high            = 1'b0;
      if (c.position_on) lamps_model[LAMP_CIRC] = 1'b1;
    end
    if (c.position_changed) begin
      lamps_model[LAMP_SIDEP] = c.position_on;
      if (is_left) lamps_model[LAMP_WHOLE] = c.position_on;
      // A lit turn lamp keeps the circles dark even when position comes on.
      if (!c.position_on || !phase_high) lamps_model[LAMP_CIRC] = c.position_on;
    end
    if (c.brake_changed) begin
      lamps_model[LAMP_SSTOP] = c.brake_on;
      if (!is_left) lamps_model[LAMP_MSTOP] = c.brake_on;
    end
    if (c.reverse_changed) lamps_model[LAMP_REV] = c.reverse_on;
    if (c.safe_request) begin
      safe_on                = 1'b1;
      safe_mark              = p.now_ms;
      lamps_model[LAMP_SAFE] = 1'b1;
      safe_requests++;
    end
    if (safe_on && ((p.now_ms - safe_mark) > TimeBits'(board_cfg.safe_hold_ms))) begin
      lamps_model[LAMP_SAFE] = 1'b0;
      safe_on                = 1'b0;
    end
    if (lamps_model[LAMP_DIR] != dir_before) dir_changes++;
    lamp_words_due.push_back(lamps_model);
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= ShownMismatches) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Valid stays up after an accepted word so that back-to-back words need no
  // extra assignment; a pause lowers it in a step of its own.
  task automatic send_pass(input pass_t p);
    int unsigned gap;
    if (tx_calm_items == 0) begin
      tx_calm       = ($urandom_range(0, 3) == 0);
      tx_calm_items = $urandom_range(20, 120);
    end
    tx_calm_items--;
    gap = tx_calm ? 0 : pick_pause();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    offered    <= p;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    compute_lamp_levels(p);
    passes_sent++;
  endtask

  task automatic hold_until_drained();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (lamp_words_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input cfg_t c);
    cfg_index_e idx;
    hold_until_drained();
    cfg_we_i <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      idx = cfg_index_e'(k);
      cfg_index_i <= idx;
      case (idx)
        CFG_BOARD_IS_LEFT:   cfg_data_i <= {15'($urandom), c.board_is_left};
        CFG_BLINK_PERIOD_MS: cfg_data_i <= c.blink_period_ms;
        CFG_BLINK_HIGH_MS:   cfg_data_i <= c.blink_high_ms;
        default:             cfg_data_i <= c.safe_hold_ms;
      endcase
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    board_cfg = c;
    settings_applied++;
  endtask

  // Mostly small steps, some aimed at the exact blink and hold thresholds,
  // and now and then a jump anywhere in the 32-bit range.
  function automatic logic [TimeBits-1:0] next_time();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      road_time_ms += $urandom_range(0, 30);
    end else if (r < 72) begin
      road_time_ms += $urandom_range(0, 600);
    end else if (r < 80) begin
      road_time_ms = blink_mark + (phase_high ? TimeBits'(board_cfg.blink_high_ms)
                                              : TimeBits'(low_time()))
                     + $urandom_range(0, 2) - 1;
    end else if (r < 86) begin
      road_time_ms = safe_mark + TimeBits'(board_cfg.safe_hold_ms) + $urandom_range(0, 1);
    end else if (r < 96) begin
      road_time_ms += $urandom_range(0, 70000);
    end else begin
      road_time_ms = $urandom;
    end
    return road_time_ms;
  endfunction

  // Returns the new level and the change pulse for one lamp command.
  function automatic logic [1:0] wiggle(input logic level);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return {~level, 1'b1};
    if (r < 6) return {level, 1'b1};
    if (r < 7) return {~level, 1'b0};
    return {level, 1'b0};
  endfunction

  function automatic cmd_t next_commands();
    cmd_t c;
    c = '0;
    if ($urandom_range(0, 99) < 3) return cmd_t'(11'($urandom));
    if ($urandom_range(0, 99) < 6) begin
      case ($urandom_range(0, 3))
        0: held_levels.left_turn = ~held_levels.left_turn;
        1: held_levels.right_turn = ~held_levels.right_turn;
        2: held_levels.hazard = ~held_levels.hazard;
        default: begin
          held_levels.left_turn  = 1'b0;
          held_levels.right_turn = 1'b0;
          held_levels.hazard     = 1'b0;
        end
      endcase
      c.indicator_changed = 1'b1;
    end else if ($urandom_range(0, 99) < 2) begin
      c.indicator_changed = 1'b1;
    end
    {held_levels.position_on, c.position_changed} = wiggle(held_levels.position_on);
    {held_levels.brake_on, c.brake_changed}       = wiggle(held_levels.brake_on);
    {held_levels.reverse_on, c.reverse_changed}   = wiggle(held_levels.reverse_on);
    c.left_turn    = held_levels.left_turn;
    c.right_turn   = held_levels.right_turn;
    c.hazard       = held_levels.hazard;
    c.position_on  = held_levels.position_on;
    c.brake_on     = held_levels.brake_on;
    c.reverse_on   = held_levels.reverse_on;
    c.safe_request = ($urandom_range(0, 99) < 3);
    return c;
  endfunction

  task automatic run_traffic(input int unsigned count);
    pass_t p;
    repeat (count) begin
      p.now_ms = next_time();
      p.cmd    = next_commands();
      send_pass(p);
    end
  endtask

  function automatic logic [15:0] rand_ms();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd0;
    if (r < 30) return 16'hFFFF;
    return 16'($urandom_range(0, 1500));
  endfunction

  // Runs on the reset configuration: wrap of the timestamp, exact blink and
  // hold thresholds, a pending indicator change, and every lamp command.
  task automatic test_directed_edges();
    send_pass(pass_of(32'h0000_0000, ""));
    send_pass(pass_of(32'hFFFF_FFFF, "LRHPBVipbvs"));
    send_pass(pass_of(32'h0000_01F2, "HP"));
    send_pass(pass_of(32'h0000_01F3, "HP"));
    send_pass(pass_of(32'h0000_03E6, "HP"));
    send_pass(pass_of(32'h0000_03E7, "HP"));
    send_pass(pass_of(32'h0000_0BB7, "Pi"));
    send_pass(pass_of(32'h0000_0BB8, "P"));
    send_pass(pass_of(32'h0000_0C00, "LPi"));
    send_pass(pass_of(32'h0000_0C10, "LPp"));
    send_pass(pass_of(32'h0000_0C20, "RPi"));
    send_pass(pass_of(32'h0000_0C30, "Bb"));
    send_pass(pass_of(32'h0000_0C40, "Vvs"));
    send_pass(pass_of(32'h0000_0C41, ""));
    send_pass(pass_of(32'h0000_0C50, "pbv"));
    send_pass(pass_of(32'h0000_0C60, "iH"));
    send_pass(pass_of(32'h0000_0C70, "H"));
    send_pass(pass_of(32'h0000_0C80, ""));
    // A second request restarts the hold, so the lamp outlives the first one.
    send_pass(pass_of(32'h0000_1000, "s"));
    send_pass(pass_of(32'h0000_17D0, "s"));
    send_pass(pass_of(32'h0000_1BB9, ""));
    send_pass(pass_of(32'h0000_2389, ""));
    road_time_ms = 32'h0000_3000;
  endtask

  task automatic test_blink_timing();
    set_config(cfg_of(1'b1, 16'd0, 16'd0, 16'd0));
    run_traffic(80);
    set_config(cfg_of(1'b1, 16'd10, 16'hFFFF, 16'hFFFF));
    run_traffic(80);
    set_config(cfg_of(1'b1, 16'hFFFF, 16'd0, 16'd1));
    run_traffic(80);
  endtask

  task automatic test_board_sides();
    set_config(cfg_of(1'b0, 16'd300, 16'd120, 16'd500));
    run_traffic(80);
    set_config(cfg_of(1'b1, 16'd200, 16'd50, 16'd100));
    run_traffic(80);
  endtask

  task automatic test_random_traffic();
    repeat (8) begin
      set_config(cfg_of(1'($urandom), rand_ms(), rand_ms(), rand_ms()));
      run_traffic(140);
    end
  endtask

  always @(posedge clk_i) begin : lamp_word_checker
    lamp_vec_t got;
    lamp_vec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got[LAMP_DIR]   = direction_lamp_o;
      got[LAMP_CIRC]  = circles_lamp_o;
      got[LAMP_SIDEP] = side_position_lamp_o;
      got[LAMP_WHOLE] = whole_position_lamp_o;
      got[LAMP_SSTOP] = side_stop_lamp_o;
      got[LAMP_MSTOP] = middle_stop_lamp_o;
      got[LAMP_REV]   = reverse_lamp_o;
      got[LAMP_SAFE]  = safe_lamp_o;
      if (lamp_words_due.size() == 0) begin
        report_mismatch($sformatf("lamp word %b with none expected", got));
      end else begin
        want = lamp_words_due.pop_front();
        for (int k = 0; k < LampCount; k++) begin
          if (got[k] !== want[k]) begin
            report_mismatch($sformatf("word %0d: %s lamp is %b, expected %b",
                                      words_checked, lamp_name(k), got[k], want[k]));
          end
        end
        words_checked++;
      end
    end
    if (rx_calm_cycles == 0) begin
      rx_calm        = ($urandom_range(0, 3) == 0);
      rx_calm_cycles = $urandom_range(50, 400);
    end
    rx_calm_cycles--;
    if (stall_run == 0 && !rx_calm && $urandom_range(0, 99) < 20) stall_run = pick_pause();
    if (stall_run != 0) begin
      out_stall_i <= 1'b1;
      stall_run--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles with %0d lamp words outstanding",
               cycle_count, lamp_words_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_blink_timing();
    test_board_sides();
    test_random_traffic();
    hold_until_drained();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d service passes under %0d register settings, both boards, %0d checked.",
             passes_sent, settings_applied, words_checked);
    $display("Turn lamp changed %0d times, %0d safe requests, %0d mismatches.",
             dir_changes, safe_requests, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
